>>> hdl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants for the chunk cache lookup
// Field widths, default depth and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int POS_W         = 32;
  localparam int SLOT_W        = 6;
  localparam int CAP_W         = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  localparam int TAG_W = $bits(pos_t);

  // lookup result from the tag array, index sized for the largest build
  typedef struct packed {
    logic        hit;
    logic [15:0] idx;
  } match_t;

  // replacement decision for a miss
  typedef struct packed {
    logic        evict;
    logic [15:0] where;
  } alloc_t;

endpackage

`default_nettype wire

>>> hdl/fcc_pos_if.sv
// ----------------------------------------------------------------------------
// fcc_pos_if: request channel
// Valid/ready channel carrying one signed 3D chunk position.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcc_pos_if;
  logic                              valid;
  logic                              ready;
  logic signed [fcc_pkg::POS_W-1:0]  pos_x;
  logic signed [fcc_pkg::POS_W-1:0]  pos_y;
  logic signed [fcc_pkg::POS_W-1:0]  pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

`default_nettype wire

>>> hdl/fcc_res_if.sv
// ----------------------------------------------------------------------------
// fcc_res_if: result channel
// Valid/ready channel carrying one lookup result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcc_res_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [fcc_pkg::SLOT_W-1:0]        slot;
  logic                              load_request;
  logic                              evicted;
  logic signed [fcc_pkg::POS_W-1:0]  evicted_x;
  logic signed [fcc_pkg::POS_W-1:0]  evicted_y;
  logic signed [fcc_pkg::POS_W-1:0]  evicted_z;

  modport source (output valid, output hit, output slot, output load_request,
                  output evicted, output evicted_x, output evicted_y,
                  output evicted_z, input ready);
  modport sink   (input valid, input hit, input slot, input load_request,
                  input evicted, input evicted_x, input evicted_y,
                  input evicted_z, output ready);
endinterface

`default_nettype wire

>>> hdl/fcc_cfg_if.sv
// ----------------------------------------------------------------------------
// fcc_cfg_if: configuration write channel
// Valid/ready channel carrying the capacity register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fcc_pkg::CAP_W-1:0]   capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

>>> hdl/fcc_ram.sv
// ----------------------------------------------------------------------------
// fcc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/fcc_tag_cam.sv
// ----------------------------------------------------------------------------
// fcc_tag_cam: fully associative tag array
// Holds one position per slot and compares a key against all slots at once.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_tag_cam #(
  parameter int SLOTS = fcc_pkg::SLOTS_DEFAULT,
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int FILL_W = $clog2(SLOTS + 1)
) (
  input  wire logic                clk,
  input  wire fcc_pkg::pos_t       key,
  input  wire logic [FILL_W-1:0]   fill_count,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_idx,
  output fcc_pkg::match_t          match
);

  fcc_pkg::pos_t    tag [SLOTS];
  logic [SLOTS-1:0] hitv;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag[wr_idx] <= key;
    end
  end

  // slots fill in order, so a slot is valid exactly when below the fill count
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hitv[s] = (FILL_W'(s) < fill_count) && (tag[s] == key);
    end
  end

  // the array never holds a duplicate, so or-ing the matching indices encodes
  always_comb begin
    idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      idx = idx | (hitv[s] ? IDX_W'(s) : '0);
    end
  end

  always_comb begin
    match.hit = |hitv;
    match.idx = 16'(idx);
  end

endmodule

`default_nettype wire

>>> hdl/fcc_repl.sv
// ----------------------------------------------------------------------------
// fcc_repl: FIFO replacement control
// Capacity register, fill count and FIFO head, with the slot choice on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_repl #(
  parameter int SLOTS = fcc_pkg::SLOTS_DEFAULT,
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int FILL_W = $clog2(SLOTS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr,
  input  wire logic [fcc_pkg::CAP_W-1:0]  cfg_data,
  input  wire logic                       go,
  input  wire logic                       hit,
  output logic      [FILL_W-1:0]          fill_count,
  output fcc_pkg::alloc_t                 alloc,
  output logic      [IDX_W-1:0]           oldest_next
);

  localparam int CMP_W = (FILL_W > fcc_pkg::CAP_W) ? FILL_W : fcc_pkg::CAP_W;

  logic [fcc_pkg::CAP_W-1:0] capacity;
  logic [IDX_W-1:0]          oldest;
  logic [FILL_W-1:0]         fill_count_next;
  logic [CMP_W-1:0]          cap_lo;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          oldest_inc;
  logic                      full;
  logic [IDX_W-1:0]          where;

  // capacity of zero acts as one, above the depth acts as the depth
  always_comb begin
    cap_lo  = (capacity == '0) ? CMP_W'(1) : CMP_W'(capacity);
    cap_eff = (cap_lo > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_lo;
    full    = CMP_W'(fill_count) >= cap_eff;
    where   = full ? oldest : fill_count[IDX_W-1:0];
    oldest_inc = CMP_W'(oldest) + CMP_W'(1);
  end

  always_comb begin
    alloc.evict = full;
    alloc.where = 16'(where);
  end

  always_comb begin
    oldest_next     = oldest;
    fill_count_next = fill_count;
    if (cfg_wr) begin
      oldest_next     = '0;
      fill_count_next = '0;
    end else if (go && !hit) begin
      if (full) begin
        oldest_next = (oldest_inc >= cap_eff) ? '0 : oldest_inc[IDX_W-1:0];
      end else begin
        fill_count_next = fill_count + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= fcc_pkg::CAP_RESET;
      oldest     <= '0;
      fill_count <= '0;
    end else begin
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      oldest     <= oldest_next;
      fill_count <= fill_count_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fifo_chunk_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// fifo_chunk_cache_lookup_unit: chunk position cache with FIFO replacement
// Fully associative lookup of a 3D position; misses fill free slots in order,
// then evict the oldest entry and report its position.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   pos_x, pos_y, pos_z
//  rsp      out  valid/ready   hit, slot, load_request, evicted, evicted_x/y/z
//  cfg      in   valid/ready   capacity_in_use (write flushes the cache)
//
//  one request per cycle sustained while rsp accepts results; the transfer
//  loads the input register, then the all-slot tag compare and FIFO update
//  load the result register. the evicted tag comes from a RAM read
//  prefetched at the next FIFO head. a stall on rsp holds the staged request
//  and stops req only when both registers are full. reset is synchronous
//  and needs no clearing pass: slot validity follows the fill count.
//
`default_nettype none

module fifo_chunk_cache_lookup_unit #(
  parameter int SLOTS = fcc_pkg::SLOTS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  fcc_pos_if.sink   req,
  fcc_res_if.source rsp,
  fcc_cfg_if.sink   cfg
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int SLOT_W = fcc_pkg::SLOT_W;
  localparam int TAG_W  = fcc_pkg::TAG_W;

  logic              s_valid;
  fcc_pkg::pos_t     s_key;
  logic              proceed;
  logic              go;
  logic              cfg_wr;
  fcc_pkg::match_t   match;
  fcc_pkg::alloc_t   alloc;
  logic [FILL_W-1:0] fill_count;
  logic [IDX_W-1:0]  oldest_next;
  logic [IDX_W-1:0]  alloc_idx;
  logic [IDX_W-1:0]  where;
  logic              wr_en;
  logic [TAG_W-1:0]  ram_q;
  logic              byp_hit;
  fcc_pkg::pos_t     byp_q;
  fcc_pkg::pos_t     ev_tag;

  assign proceed   = !rsp.valid || rsp.ready;
  assign go        = s_valid && proceed;
  assign req.ready = !s_valid || proceed;
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_key <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
    end
  end

  fcc_tag_cam #(.SLOTS(SLOTS)) u_cam (
    .clk        (clk),
    .key        (s_key),
    .fill_count (fill_count),
    .wr_en      (wr_en),
    .wr_idx     (alloc_idx),
    .match      (match)
  );

  fcc_repl #(.SLOTS(SLOTS)) u_repl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg.capacity_in_use),
    .go          (go),
    .hit         (match.hit),
    .fill_count  (fill_count),
    .alloc       (alloc),
    .oldest_next (oldest_next)
  );

  assign alloc_idx = alloc.where[IDX_W-1:0];
  assign wr_en     = go && !match.hit;
  assign where     = match.hit ? match.idx[IDX_W-1:0] : alloc_idx;

  // copy of the tags for reading out the entry at the FIFO head
  fcc_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_evict_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (alloc_idx),
    .wdata (s_key),
    .raddr (oldest_next),
    .rdata (ram_q)
  );

  // the RAM returns old data when the head slot is written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= wr_en && (alloc_idx == oldest_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_q <= s_key;
  end

  assign ev_tag = byp_hit ? byp_q : fcc_pkg::pos_t'(ram_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (proceed) begin
      rsp.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.hit          <= match.hit;
      rsp.slot         <= SLOT_W'(where);
      rsp.load_request <= !match.hit;
      rsp.evicted      <= !match.hit && alloc.evict;
      if (!match.hit && alloc.evict) begin
        rsp.evicted_x <= ev_tag.x;
        rsp.evicted_y <= ev_tag.y;
        rsp.evicted_z <= ev_tag.z;
      end else begin
        rsp.evicted_x <= '0;
        rsp.evicted_y <= '0;
        rsp.evicted_z <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/fifo_chunk_cache_lookup_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_chunk_cache_lookup_unit_tb: self-checking bench for the chunk cache
// Streams 3D positions through the lookup channel with random idle cycles on
// both sides. A local copy of the tag store and the FIFO head predicts each
// result. Directed sequences cover extreme coordinates, hits, fills and
// evictions. Random phases at several capacities reuse a working set so that
// hits and evictions both show up.
// ----------------------------------------------------------------------------

module fifo_chunk_cache_lookup_unit_tb;

  localparam int NSLOTS     = fcc_pkg::SLOTS_DEFAULT;
  localparam int POS_W      = fcc_pkg::POS_W;
  localparam int SLOT_W     = fcc_pkg::SLOT_W;
  localparam int CAP_W      = fcc_pkg::CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = fcc_pkg::CAP_RESET;
  localparam int HALF_CLK   = 6;
  localparam int CYCLE_CAP  = 800000;
  localparam int SETTLE     = 6;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;

  typedef fcc_pkg::pos_t pos_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              load_request;
    logic              evicted;
    pos_t              evicted_pos;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst;

  fcc_pos_if req_if ();
  fcc_res_if rsp_if ();
  fcc_cfg_if cfg_if ();

  fifo_chunk_cache_lookup_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #HALF_CLK clk = ~clk;

  // shadow of the cache contents
  pos_t               shadow_tag   [NSLOTS];
  bit                 shadow_valid [NSLOTS];
  int unsigned        shadow_fill;
  int unsigned        shadow_head;
  logic [CAP_W-1:0]   shadow_cap;

  pos_t               pending_pos [$];
  lookup_result_t     expected_results [$];
  pos_t               working_set [$];

  int  errors;
  int  cycle_count;
  int  lookups_done;
  int  hits_seen;
  int  evictions_seen;
  int  cap_writes;
  int  send_gap;
  int  send_quiet;
  int  drain_stall;
  int  drain_quiet;

  function automatic pos_t make_pos(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                    logic signed [POS_W-1:0] z);
    pos_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic int unsigned active_slots();
    int unsigned c;
    c = 32'(shadow_cap);
    if (c < 1) c = 1;
    if (c > NSLOTS) c = NSLOTS;
    return c;
  endfunction

  function automatic void flush_shadow();
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    shadow_fill = 0;
    shadow_head = 0;
  endfunction

  task automatic queue_pos(pos_t p);
    pending_pos.insert(pending_pos.size(), p);
  endtask

  function automatic lookup_result_t predict_lookup(pos_t p);
    lookup_result_t r;
    bit             found;
    int unsigned    where;
    int unsigned    cap;
    found = 1'b0;
    where = 0;
    cap   = active_slots();
    r     = '0;
    for (int s = 0; s < NSLOTS; s++) begin
      if (!found && shadow_valid[s] && shadow_tag[s] === p) begin
        found = 1'b1;
        where = s;
      end
    end
    if (!found) begin
      if (shadow_fill < cap) begin
        where = shadow_fill;
        shadow_fill++;
      end else begin
        // full: reuse the oldest slot and advance the head around the ring
        where         = shadow_head;
        r.evicted     = 1'b1;
        r.evicted_pos = shadow_tag[where];
        shadow_head   = (where + 1 >= cap) ? 0 : where + 1;
        evictions_seen++;
      end
      shadow_tag[where]   = p;
      shadow_valid[where] = 1'b1;
    end else begin
      hits_seen++;
    end
    r.hit          = found;
    r.load_request = !found;
    r.slot         = where[SLOT_W-1:0];
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones, and quiet stretches
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [POS_W-1:0] random_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 80) return $signed($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0:       return POS_MIN;
      1:       return POS_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic pos_t random_pos();
    return make_pos(random_coord(), random_coord(), random_coord());
  endfunction

  task automatic report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
    $display("[%0t] ERROR %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic wait_idle();
    while (pending_pos.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.capacity_in_use <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_cap = value;
    flush_shadow();
    cap_writes++;
  endtask

  // working set a bit larger than the capacity, so both hits and evictions occur
  task automatic queue_random_phase(int count, bit keep_set);
    int   set_size;
    int   r;
    pos_t p;
    if (!keep_set || working_set.size() == 0) begin
      working_set.delete();
      set_size = active_slots() + $urandom_range(1, active_slots() / 2 + 2);
      repeat (set_size) working_set.insert(working_set.size(), random_pos());
    end
    repeat (count) begin
      r = $urandom_range(0, 99);
      p = working_set[$urandom_range(0, working_set.size() - 1)];
      if (r >= 90) begin
        p = random_pos();
      end else if (r >= 78) begin
        // same position but for one coordinate
        case ($urandom_range(0, 2))
          0:       p.x = random_coord();
          1:       p.y = random_coord();
          default: p.z = random_coord();
        endcase
      end
      queue_pos(p);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap     = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.insert(expected_results.size(),
          predict_lookup(make_pos(req_if.pos_x, req_if.pos_y, req_if.pos_z)));
        lookups_done++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_pos.size() != 0) begin
          pos_t p;
          p = pending_pos[0];
          pending_pos.delete(0);
          req_if.valid <= 1'b1;
          req_if.pos_x <= p.x;
          req_if.pos_y <= p.y;
          req_if.pos_z <= p.z;
          send_gap = pick_gap(send_quiet);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      drain_stall  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", POS_W'(rsp_if.slot), '0);
        end else begin
          lookup_result_t want;
          want = expected_results[0];
          expected_results.delete(0);
          if (rsp_if.hit !== want.hit)
            report_mismatch("hit", POS_W'(rsp_if.hit), POS_W'(want.hit));
          if (rsp_if.slot !== want.slot)
            report_mismatch("slot", POS_W'(rsp_if.slot), POS_W'(want.slot));
          if (rsp_if.load_request !== want.load_request)
            report_mismatch("load_request", POS_W'(rsp_if.load_request),
                            POS_W'(want.load_request));
          if (rsp_if.evicted !== want.evicted)
            report_mismatch("evicted", POS_W'(rsp_if.evicted), POS_W'(want.evicted));
          if (rsp_if.evicted_x !== want.evicted_pos.x)
            report_mismatch("evicted_x", rsp_if.evicted_x, want.evicted_pos.x);
          if (rsp_if.evicted_y !== want.evicted_pos.y)
            report_mismatch("evicted_y", rsp_if.evicted_y, want.evicted_pos.y);
          if (rsp_if.evicted_z !== want.evicted_pos.z)
            report_mismatch("evicted_z", rsp_if.evicted_z, want.evicted_pos.z);
        end
      end
      if (drain_stall > 0) begin
        drain_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        drain_stall = pick_gap(drain_quiet);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("fifo_chunk_cache_lookup_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_cap   [11];
    int               phase_items [11];
    bit               phase_keep  [11];
    pos_t             pa;
    pos_t             pb;
    pos_t             pc;

    phase_cap   = '{7'd1, 7'd3, 7'd127, 7'd64, 7'd64, 7'd65,
                    7'd8, 7'd33, 7'd0, 7'd5, 7'd16};
    phase_items = '{60, 100, 250, 200, 60, 100, 150, 150, 140, 100, 90};
    phase_keep  = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};

    rst                    = 1'b1;
    req_if.valid           = 1'b0;
    req_if.pos_x           = '0;
    req_if.pos_y           = '0;
    req_if.pos_z           = '0;
    rsp_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.capacity_in_use = '0;
    errors         = 0;
    cycle_count    = 0;
    lookups_done   = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    cap_writes     = 0;
    send_quiet     = 0;
    drain_quiet    = 0;
    shadow_cap     = CAP_RESET;
    flush_shadow();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: extreme coordinates, hits, single coordinate differences
    pa = make_pos(POS_MIN, POS_MIN, POS_MIN);
    pb = make_pos(POS_MAX, POS_MAX, POS_MAX);
    pc = make_pos(POS_MIN, POS_MAX, '0);
    queue_pos(make_pos('0, '0, '0));
    queue_pos(pa);
    queue_pos(pb);
    queue_pos(make_pos('1, '1, '1));
    queue_pos(pc);
    queue_pos(make_pos('0, '0, '0));
    queue_pos(pb);
    queue_pos(make_pos('0, '0, 32'sd1));
    queue_pos(make_pos('0, 32'sd1, '0));
    queue_pos(make_pos(32'sd1, '0, '0));
    queue_pos(pc);
    queue_pos(pa);
    wait_idle();

    // two slots: fill, evict in order, hit after a wrap
    write_capacity(7'd2);
    queue_pos(make_pos('1, '1, '1));
    queue_pos(pb);
    queue_pos(pa);
    queue_pos(make_pos('1, '1, '1));
    queue_pos(pa);
    queue_pos(pb);
    queue_pos(pb);
    wait_idle();

    // zero capacity behaves as one slot
    write_capacity(7'd0);
    queue_pos(pa);
    queue_pos(pa);
    queue_pos(pb);
    queue_pos(pa);
    wait_idle();

    phase_cap[8] = CAP_W'($urandom_range(0, 127));
    foreach (phase_cap[i]) begin
      write_capacity(phase_cap[i]);
      queue_random_phase(phase_items[i], phase_keep[i]);
      wait_idle();
    end

    repeat (SETTLE * 2) @(posedge clk);
    $display("covered %0d lookups: %0d hits, %0d misses, %0d evictions",
             lookups_done, hits_seen, lookups_done - hits_seen, evictions_seen);
    $display("capacity rewritten %0d times, %0d errors", cap_writes, errors);
    if (errors == 0) begin
      $display("fifo_chunk_cache_lookup_unit: match");
    end else begin
      $display("fifo_chunk_cache_lookup_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> fifo_chunk_cache_lookup_unit.f
hdl/fcc_pkg.sv
hdl/fcc_pos_if.sv
hdl/fcc_res_if.sv
hdl/fcc_cfg_if.sv
hdl/fcc_ram.sv
hdl/fcc_tag_cam.sv
hdl/fcc_repl.sv
hdl/fifo_chunk_cache_lookup_unit.sv
verif/fifo_chunk_cache_lookup_unit_tb.sv
